/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EGD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EGD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/egd_pkg.sv */
// types and constants of the exp-golomb decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package egd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 3;
  localparam int unsigned ZrunW   = 5;
  localparam int unsigned AccW    = 32;
  localparam int unsigned ValueW  = 33;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  // head of the byte queue as seen by the bit engine
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } byte_chan_t;

  // finished code: leading one plus suffix bits, or an error
  typedef struct packed {
    logic            err;
    logic [AccW-1:0] acc;
  } code_res_t;

endpackage

`default_nettype wire

/* rtl/core/egd_front.sv */
// front end: accepts bytes and queues them for the bit engine
// depends on egd_pkg
`timescale 1ns / 1ps
`default_nettype none

module egd_front
  import egd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] stream_byte_i,
  output byte_chan_t            head_o,
  input  wire logic             pop_i
);

  logic [ByteW-1:0] mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign in_ready_o = (cnt_q != QCntW'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= stream_byte_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/egd_back.sv */
// back end: bit-serial exp-golomb engine, pending code slot and result register
// depends on egd_pkg
`timescale 1ns / 1ps
`default_nettype none

module egd_back
  import egd_pkg::*;
#(
  parameter int unsigned MAX_ZERO_RUN = 31
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              signed_mode_i,
  input  byte_chan_t             head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [ValueW-1:0] code_value_o,
  output logic                   code_error_o,
  output logic                   last_of_byte_o
);

  // bit engine state
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ZrunW-1:0] zero_run_q, zero_run_d;
  logic             in_suffix_q, in_suffix_d;
  logic [ZrunW-1:0] suffix_left_q, suffix_left_d;
  logic [AccW-1:0]  acc_q, acc_d;

  // pending code, held until the next code or the end of its byte
  logic             pend_valid_q, pend_valid_d;
  logic             pend_closed_q, pend_closed_d;
  code_res_t        pend_q, pend_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q, out_value_d;
  logic              out_err_q, out_err_d;
  logic              out_last_q, out_last_d;

  logic              bit_w;
  logic              res_hit;
  code_res_t         res;
  logic              out_free;
  logic              step_go;
  logic              push_pend;
  logic              byte_end;
  logic [ValueW-1:0] half;
  logic [ValueW-1:0] mapped;

  assign bit_w    = head_i.data[pos_q];
  assign out_free = !out_valid_q || out_ready_i;
  assign step_go  = head_i.valid && (!res_hit || !pend_valid_q || out_free);
  assign byte_end = (pos_q == '0);
  assign pop_o    = step_go && byte_end;
  assign push_pend = pend_valid_q && out_free && ((step_go && res_hit) || pend_closed_q);

  // one bit of the code
  always_comb begin
    zero_run_d    = zero_run_q;
    in_suffix_d   = in_suffix_q;
    suffix_left_d = suffix_left_q;
    acc_d         = acc_q;
    res_hit       = 1'b0;
    res.err       = 1'b0;
    res.acc       = acc_q;
    if (in_suffix_q) begin
      acc_d         = {acc_q[AccW-2:0], bit_w};
      suffix_left_d = suffix_left_q - 1'b1;
      if (suffix_left_q == ZrunW'(1)) begin
        res_hit     = 1'b1;
        res.acc     = {acc_q[AccW-2:0], bit_w};
        in_suffix_d = 1'b0;
        zero_run_d  = '0;
      end
    end else if (!bit_w) begin
      if (zero_run_q >= ZrunW'(MAX_ZERO_RUN)) begin
        res_hit    = 1'b1;
        res.err    = 1'b1;
        zero_run_d = '0;
      end else begin
        zero_run_d = zero_run_q + 1'b1;
      end
    end else if (zero_run_q == '0) begin
      res_hit = 1'b1;
      res.acc = AccW'(1);
    end else begin
      in_suffix_d   = 1'b1;
      suffix_left_d = zero_run_q;
      acc_d         = AccW'(1);
    end
  end

  // acc holds 2^z + suffix, so ue = acc - 1 and se = +/- (acc >> 1)
  always_comb begin
    half = {2'b00, pend_q.acc[AccW-1:1]};
    if (pend_q.err) begin
      mapped = '0;
    end else if (signed_mode_i) begin
      mapped = pend_q.acc[0] ? (ValueW'(0) - half) : half;
    end else begin
      mapped = {1'b0, pend_q.acc} - ValueW'(1);
    end
  end

  always_comb begin
    pos_d         = pos_q;
    pend_valid_d  = pend_valid_q;
    pend_closed_d = pend_closed_q;
    pend_d        = pend_q;
    out_valid_d   = out_valid_q;
    out_value_d   = out_value_q;
    out_err_d     = out_err_q;
    out_last_d    = out_last_q;
    if (step_go) begin
      pos_d = pos_q - 1'b1;
    end
    if (step_go && res_hit) begin
      pend_valid_d  = 1'b1;
      pend_closed_d = byte_end;
      pend_d        = res;
    end else if (push_pend) begin
      pend_valid_d  = 1'b0;
      pend_closed_d = 1'b0;
    end else if (step_go && byte_end && pend_valid_q) begin
      pend_closed_d = 1'b1;
    end
    if (push_pend) begin
      out_valid_d = 1'b1;
      out_value_d = mapped;
      out_err_d   = pend_q.err;
      out_last_d  = pend_closed_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '1;
      zero_run_q    <= '0;
      in_suffix_q   <= 1'b0;
      suffix_left_q <= '0;
      pend_valid_q  <= 1'b0;
      pend_closed_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      pos_q         <= pos_d;
      pend_valid_q  <= pend_valid_d;
      pend_closed_q <= pend_closed_d;
      out_valid_q   <= out_valid_d;
      if (step_go) begin
        zero_run_q    <= zero_run_d;
        in_suffix_q   <= in_suffix_d;
        suffix_left_q <= suffix_left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      acc_q <= acc_d;
    end
    pend_q      <= pend_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign code_value_o   = out_value_q;
  assign code_error_o   = out_err_q;
  assign last_of_byte_o = out_last_q;

endmodule

`default_nettype wire

/* rtl/core/exp_golomb_bit_decoder.sv */
// top level of the order-0 exp-golomb ue/se decoder
// depends on egd_pkg, egd_front, egd_back and assert_macros.svh
//
//   channel  signals                                  direction
//   input    in_valid_i in_ready_o stream_byte_i       in
//   output   out_valid_o out_ready_i code_value_o      out
//            code_error_o last_of_byte_o
//   config   cfg_we_i cfg_wdata_i                      in
//
// a byte passes through the bit engine one bit per cycle while the engine is not stalled
// a two-item byte queue lets new bytes in while the engine works
// a finished code waits in a pending slot until the next code or the end of its byte
// the engine stalls only when a new code finds the pending slot and result register full
// reset is asynchronous and clears all control state at once
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module exp_golomb_bit_decoder
  import egd_pkg::*;
#(
  parameter int unsigned MAX_ZERO_RUN = 31
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [ByteW-1:0]    stream_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [ValueW-1:0] code_value_o,
  output logic                     code_error_o,
  output logic                     last_of_byte_o
);

  logic       signed_mode_q;
  byte_chan_t head;
  logic       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      signed_mode_q <= cfg_wdata_i;
    end
  end

  egd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .head_o        (head),
    .pop_i         (pop)
  );

  egd_back #(
    .MAX_ZERO_RUN (MAX_ZERO_RUN)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .signed_mode_i  (signed_mode_q),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_value_o   (code_value_o),
    .code_error_o   (code_error_o),
    .last_of_byte_o (last_of_byte_o)
  );

  `EGD_ASSERT_IMP(a_pop_has_byte, clk_i, rst_ni, pop, head.valid, "pop from empty queue")
  `EGD_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && code_error_o, code_value_o == '0, "error item with nonzero value")
  `EGD_ASSERT_IMP(a_ue_nonneg, clk_i, rst_ni, out_valid_o && !signed_mode_q, !code_value_o[ValueW-1], "negative ue value")

endmodule

`default_nettype wire
